// ===== rtl/core/ipc_pkg.sv =====
`timescale 1ns / 1ps

package ipc_pkg;

	localparam int OpW      = 2;
	localparam int PctW     = 7;
	localparam int SecW     = 16;
	localparam int EvW      = 3;
	localparam int CntW     = 32;
	localparam int MsPerSec = 1000;
	// widest threshold in ms: 65535 * 1000 fits in 26 bits
	localparam int MsThrW   = 26;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = SecW;

	localparam logic [OpW-1:0] OP_TICK   = 2'd0;
	localparam logic [OpW-1:0] OP_SAMPLE = 2'd1;
	localparam logic [OpW-1:0] OP_TOGGLE = 2'd2;
	localparam logic [OpW-1:0] OP_MANUAL = 2'd3;

	localparam logic [EvW-1:0] EV_NONE        = 3'd0;
	localparam logic [EvW-1:0] EV_AUTO_ON     = 3'd1;
	localparam logic [EvW-1:0] EV_MANUAL_ON   = 3'd2;
	localparam logic [EvW-1:0] EV_OFF_TARGET  = 3'd3;
	localparam logic [EvW-1:0] EV_OFF_TIMEOUT = 3'd4;
	localparam logic [EvW-1:0] EV_OFF_MANUAL  = 3'd5;
	localparam logic [EvW-1:0] EV_OFF_ERROR   = 3'd6;
	localparam logic [EvW-1:0] EV_OFF_MODE    = 3'd7;

	localparam logic [CfgIdxW-1:0] REG_MOISTURE_LOW  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MOISTURE_HIGH = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_WATER     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_COOLDOWN      = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MANUAL_WATER  = 3'd4;

	localparam logic [PctW-1:0]   RST_MOISTURE_LOW  = 7'd30;
	localparam logic [PctW-1:0]   RST_MOISTURE_HIGH = 7'd60;
	localparam logic [MsThrW-1:0] RST_MAX_WATER_MS  = MsThrW'(60 * MsPerSec);
	localparam logic [MsThrW-1:0] RST_COOLDOWN_MS   = MsThrW'(300 * MsPerSec);
	localparam logic [MsThrW-1:0] RST_MANUAL_MS     = MsThrW'(10 * MsPerSec);

	typedef struct packed {
		logic [PctW-1:0]   moisture_low;
		logic [PctW-1:0]   moisture_high;
		logic [MsThrW-1:0] max_water_ms;
		logic [MsThrW-1:0] cooldown_ms;
		logic [MsThrW-1:0] manual_water_ms;
	} cfg_t;

	typedef struct packed {
		logic [OpW-1:0]  op;
		logic [PctW-1:0] moisture;
		logic            sensor_fault;
	} item_t;

endpackage

// ===== rtl/core/ipc_if.sv =====
`timescale 1ns / 1ps

interface ipc_item_if;
	logic                      valid;
	logic                      ready;
	logic [ipc_pkg::OpW-1:0]   op;
	logic [ipc_pkg::PctW-1:0]  moisture;
	logic                      sensor_fault;

	modport source (output valid, output op, output moisture, output sensor_fault,
		input ready);
	modport sink (input valid, input op, input moisture, input sensor_fault,
		output ready);
endinterface

interface ipc_result_if;
	logic                     valid;
	logic                     ready;
	logic                     pump_on;
	logic                     manual_mode;
	logic                     fault;
	logic [ipc_pkg::EvW-1:0]  event_res;

	modport source (output valid, output pump_on, output manual_mode, output fault,
		output event_res, input ready);
	modport sink (input valid, input pump_on, input manual_mode, input fault,
		input event_res, output ready);
endinterface

// ===== rtl/core/ipc_cfg.sv =====
`timescale 1ns / 1ps

module ipc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ipc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [ipc_pkg::CfgDataW-1:0]   cfg_data,
	output ipc_pkg::cfg_t                  cfg
);

	logic [ipc_pkg::MsThrW-1:0] data_ms;

	// durations are held in ms so the per-item compares need no multiplier
	assign data_ms = ipc_pkg::MsThrW'(cfg_data[ipc_pkg::SecW-1:0])
		* ipc_pkg::MsThrW'(ipc_pkg::MsPerSec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.moisture_low    <= ipc_pkg::RST_MOISTURE_LOW;
			cfg.moisture_high   <= ipc_pkg::RST_MOISTURE_HIGH;
			cfg.max_water_ms    <= ipc_pkg::RST_MAX_WATER_MS;
			cfg.cooldown_ms     <= ipc_pkg::RST_COOLDOWN_MS;
			cfg.manual_water_ms <= ipc_pkg::RST_MANUAL_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ipc_pkg::REG_MOISTURE_LOW:  cfg.moisture_low    <= cfg_data[ipc_pkg::PctW-1:0];
				ipc_pkg::REG_MOISTURE_HIGH: cfg.moisture_high   <= cfg_data[ipc_pkg::PctW-1:0];
				ipc_pkg::REG_MAX_WATER:     cfg.max_water_ms    <= data_ms;
				ipc_pkg::REG_COOLDOWN:      cfg.cooldown_ms     <= data_ms;
				ipc_pkg::REG_MANUAL_WATER:  cfg.manual_water_ms <= data_ms;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/irrigation_pump_controller_core.sv =====
`timescale 1ns / 1ps

// Irrigation pump controller: one beat per clock on item unless the result register
// stalls, and exactly one result beat per item (input register, then result register);
// an unstalled stream runs at one item per cycle. The whole state update is a single
// pass of compare-and-count logic between those two registers. Durations are converted
// to ms once, when a register is written. Time counters saturate at 2^32-1.
module irrigation_pump_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	ipc_item_if.sink                      item,
	ipc_result_if.source                  result,
	input  logic                          cfg_we,
	input  logic [ipc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ipc_pkg::CfgDataW-1:0]  cfg_data
);

	ipc_pkg::cfg_t  cfg;
	ipc_pkg::item_t item_s1;
	logic           valid_s1;
	logic           adv_s1;

	logic                        mode_q, pump_q, fault_q;
	logic [ipc_pkg::PctW-1:0]    moist_q;
	logic [ipc_pkg::CntW-1:0]    run_q, idle_q;

	logic                        mode_n, pump_n, fault_n, do_auto;
	logic [ipc_pkg::PctW-1:0]    moist_n;
	logic [ipc_pkg::CntW-1:0]    run_n, idle_n;
	logic [ipc_pkg::EvW-1:0]     ev;

	logic                        out_valid_q;
	logic                        pump_out_q, mode_out_q, fault_out_q;
	logic [ipc_pkg::EvW-1:0]     ev_out_q;

	ipc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv_s1     = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.op           <= item.op;
			item_s1.moisture     <= item.moisture;
			item_s1.sensor_fault <= item.sensor_fault;
		end
	end

	always_comb begin
		mode_n  = mode_q;
		pump_n  = pump_q;
		fault_n = fault_q;
		moist_n = moist_q;
		run_n   = run_q;
		idle_n  = idle_q;
		ev      = ipc_pkg::EV_NONE;
		do_auto = 1'b0;

		unique case (item_s1.op)
			ipc_pkg::OP_TICK: begin
				if (pump_q) begin
					if (run_q != '1) run_n = run_q + 1'b1;
				end else begin
					if (idle_q != '1) idle_n = idle_q + 1'b1;
				end
				do_auto = 1'b1;
			end
			ipc_pkg::OP_SAMPLE: begin
				moist_n = item_s1.moisture;
				fault_n = item_s1.sensor_fault;
				if (mode_q && pump_q &&
						run_q >= ipc_pkg::CntW'(cfg.manual_water_ms)) begin
					pump_n = 1'b0;
					idle_n = '0;
					ev     = ipc_pkg::EV_OFF_MANUAL;
				end else begin
					do_auto = 1'b1;
				end
			end
			ipc_pkg::OP_TOGGLE: begin
				mode_n = !mode_q;
				if (!mode_q && pump_q) begin
					pump_n = 1'b0;
					idle_n = '0;
					ev     = ipc_pkg::EV_OFF_MODE;
				end
			end
			default: begin
				if (mode_q && !pump_q) begin
					pump_n = 1'b1;
					run_n  = '0;
					ev     = ipc_pkg::EV_MANUAL_ON;
				end
			end
		endcase

		// auto control sees the counters and sample as just updated
		if (do_auto && !mode_q) begin
			if (fault_n) begin
				if (pump_q) begin
					pump_n = 1'b0;
					idle_n = '0;
					ev     = ipc_pkg::EV_OFF_ERROR;
				end
			end else if (!pump_q) begin
				if (moist_n < cfg.moisture_low &&
						idle_n >= ipc_pkg::CntW'(cfg.cooldown_ms)) begin
					pump_n = 1'b1;
					run_n  = '0;
					ev     = ipc_pkg::EV_AUTO_ON;
				end
			end else if (moist_n >= cfg.moisture_high) begin
				pump_n = 1'b0;
				idle_n = '0;
				ev     = ipc_pkg::EV_OFF_TARGET;
			end else if (run_n >= ipc_pkg::CntW'(cfg.max_water_ms)) begin
				pump_n = 1'b0;
				idle_n = '0;
				ev     = ipc_pkg::EV_OFF_TIMEOUT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			pump_q  <= 1'b0;
			fault_q <= 1'b0;
			moist_q <= '0;
			run_q   <= '0;
			idle_q  <= '0;
		end else if (adv_s1) begin
			mode_q  <= mode_n;
			pump_q  <= pump_n;
			fault_q <= fault_n;
			moist_q <= moist_n;
			run_q   <= run_n;
			idle_q  <= idle_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pump_out_q  <= pump_n;
			mode_out_q  <= mode_n;
			fault_out_q <= fault_n;
			ev_out_q    <= ev;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.pump_on     = pump_out_q;
	assign result.manual_mode = mode_out_q;
	assign result.fault       = fault_out_q;
	assign result.event_res   = ev_out_q;

endmodule

// ===== rtl/core/ipc_checker.sv =====
`timescale 1ns / 1ps

module ipc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        pump_on,
	input logic                        manual_mode,
	input logic [ipc_pkg::EvW-1:0]     event_res
);

	// a start event leaves the pump running
	a_on_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == ipc_pkg::EV_AUTO_ON ||
			event_res == ipc_pkg::EV_MANUAL_ON) |-> pump_on)
		else $error("start beat with pump off");

	// every stop event leaves the pump off
	a_off_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == ipc_pkg::EV_OFF_TARGET ||
			event_res == ipc_pkg::EV_OFF_TIMEOUT ||
			event_res == ipc_pkg::EV_OFF_MANUAL ||
			event_res == ipc_pkg::EV_OFF_ERROR ||
			event_res == ipc_pkg::EV_OFF_MODE) |-> !pump_on)
		else $error("stop beat with pump on");

	// manual-only events come in manual mode, auto-only events in auto mode
	a_mode_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == ipc_pkg::EV_MANUAL_ON ||
			event_res == ipc_pkg::EV_OFF_MANUAL ||
			event_res == ipc_pkg::EV_OFF_MODE) |-> manual_mode)
		else $error("manual event outside manual mode");

	a_auto_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == ipc_pkg::EV_AUTO_ON ||
			event_res == ipc_pkg::EV_OFF_TARGET ||
			event_res == ipc_pkg::EV_OFF_TIMEOUT ||
			event_res == ipc_pkg::EV_OFF_ERROR) |-> !manual_mode)
		else $error("auto event in manual mode");

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(pump_on))
		else $error("result beat changed while stalled");

endmodule

bind irrigation_pump_controller_core ipc_checker u_ipc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.pump_on     (result.pump_on),
	.manual_mode (result.manual_mode),
	.event_res   (result.event_res)
);
